FILE: src/assert_macros.svh
// Assertion macros for the top-level RTL file of the timer table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant failed");

`endif

FILE: src/ostt_pkg.sv
// Package with the constants, codes and handshake types of the timer table.
`timescale 1ns / 1ps
package ostt_pkg;

   localparam int NUM_SLOTS  = 8;
   localparam int NUM_EVENTS = 8;

   localparam int EVENT_W     = 3;
   localparam int DELAY_W     = 16;
   localparam int MASK_W      = 8;
   localparam int OUT_BUSY_W  = 4;
   localparam int EVENT_CMP_W = 7;
   localparam int BUSY_MAX    = 255 & 15;

   localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int BUSY_W = $clog2(NUM_SLOTS + 1);
   localparam int SAT_W  = (BUSY_W > OUT_BUSY_W) ? BUSY_W : OUT_BUSY_W;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_SET  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_TICK    = 2'd0,
      STATUS_RELOAD  = 2'd1,
      STATUS_NEW     = 2'd2,
      STATUS_DROPPED = 2'd3
   } set_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic start;
      logic step;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_last;
   } dp_status_type;

   // The busy count leaves the block clamped to the width of its output field.
   function automatic logic [OUT_BUSY_W-1:0] sat_busy(input logic [BUSY_W-1:0] count);
      logic [SAT_W-1:0] wide;
      wide = SAT_W'(count);
      if (wide > SAT_W'(BUSY_MAX)) begin
         sat_busy = OUT_BUSY_W'(BUSY_MAX);
      end else begin
         sat_busy = wide[OUT_BUSY_W-1:0];
      end
   endfunction

endpackage

FILE: src/ostt_ctrl.sv
// Controller state machine that sequences the slot scan and the result handoff.
`timescale 1ns / 1ps
module ostt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  ostt_pkg::dp_status_type dp_status,
   output ostt_pkg::dp_cmd_type    dp_cmd
);
   import ostt_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   // The output register can take a new result when it is empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (dp_status.scan_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready    = 1'b0;
      dp_cmd.start  = 1'b0;
      dp_cmd.step   = 1'b0;
      dp_cmd.commit = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready   = 1'b1;
            dp_cmd.start = req_tvalid;
         end
         ST_SCAN: begin
            dp_cmd.step = 1'b1;
         end
         ST_FINISH: begin
            dp_cmd.commit = out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (dp_cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

FILE: src/ostt_dp.sv
// Datapath with the slot table, the scan pointer and the result register.
`timescale 1ns / 1ps
module ostt_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  ostt_pkg::dp_cmd_type                dp_cmd,
   output ostt_pkg::dp_status_type             dp_status,
   input  logic                                in_command,
   input  logic [ostt_pkg::EVENT_W-1:0]        in_event_id,
   input  logic [ostt_pkg::DELAY_W-1:0]        in_delay_ticks,
   output logic [ostt_pkg::MASK_W-1:0]         out_fired_mask,
   output ostt_pkg::set_status_type            out_set_status,
   output logic [ostt_pkg::OUT_BUSY_W-1:0]     out_busy_slots
);
   import ostt_pkg::*;

   // Slot table; only the valid bits are reset.
   logic                 slot_valid_ff [NUM_SLOTS];
   logic                 slot_valid_in [NUM_SLOTS];
   logic [EVENT_W-1:0]   slot_event_ff [NUM_SLOTS];
   logic [EVENT_W-1:0]   slot_event_in [NUM_SLOTS];
   logic [DELAY_W-1:0]   slot_rem_ff   [NUM_SLOTS];
   logic [DELAY_W-1:0]   slot_rem_in   [NUM_SLOTS];

   logic [BUSY_W-1:0]    busy_ff, busy_in;
   logic [IDX_W-1:0]     scan_idx_ff, scan_idx_in;
   logic [MASK_W-1:0]    fired_ff, fired_in;
   logic                 match_found_ff, match_found_in;
   logic [IDX_W-1:0]     match_idx_ff, match_idx_in;
   logic                 free_found_ff, free_found_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;

   logic                 item_cmd_ff, item_cmd_in;
   logic [EVENT_W-1:0]   item_ev_ff, item_ev_in;
   logic [DELAY_W-1:0]   item_delay_ff, item_delay_in;

   logic [MASK_W-1:0]     res_fired_ff, res_fired_in;
   set_status_type        res_status_ff, res_status_in;
   logic [OUT_BUSY_W-1:0] res_busy_ff, res_busy_in;

   logic                 cur_valid;
   logic [EVENT_W-1:0]   cur_event;
   logic [DELAY_W-1:0]   cur_rem;
   logic                 event_ok;

   assign cur_valid = slot_valid_ff[scan_idx_ff];
   assign cur_event = slot_event_ff[scan_idx_ff];
   assign cur_rem   = slot_rem_ff[scan_idx_ff];

   assign event_ok = {{(EVENT_CMP_W-EVENT_W){1'b0}}, item_ev_ff} < EVENT_CMP_W'(NUM_EVENTS);

   assign dp_status.scan_last = (scan_idx_ff == IDX_W'(NUM_SLOTS - 1));

   assign item_cmd_in   = dp_cmd.start ? in_command     : item_cmd_ff;
   assign item_ev_in    = dp_cmd.start ? in_event_id    : item_ev_ff;
   assign item_delay_in = dp_cmd.start ? in_delay_ticks : item_delay_ff;

   always_comb begin
      slot_valid_in  = slot_valid_ff;
      slot_event_in  = slot_event_ff;
      slot_rem_in    = slot_rem_ff;
      busy_in        = busy_ff;
      scan_idx_in    = scan_idx_ff;
      fired_in       = fired_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      res_fired_in   = res_fired_ff;
      res_status_in  = res_status_ff;
      res_busy_in    = res_busy_ff;

      if (dp_cmd.start) begin
         scan_idx_in    = '0;
         fired_in       = '0;
         match_found_in = 1'b0;
         free_found_in  = 1'b0;
      end else if (dp_cmd.step) begin
         scan_idx_in = scan_idx_ff + IDX_W'(1);
         if (item_cmd_ff == CMD_TICK) begin
            if (cur_valid) begin
               if (cur_rem != '0) begin
                  slot_rem_in[scan_idx_ff] = cur_rem - DELAY_W'(1);
               end else begin
                  slot_valid_in[scan_idx_ff] = 1'b0;
                  fired_in[cur_event]        = 1'b1;
                  busy_in                    = busy_ff - BUSY_W'(1);
               end
            end
         end else begin
            // Events are unique in the table, so at most one slot can match.
            if (cur_valid && (cur_event == item_ev_ff)) begin
               match_found_in = 1'b1;
               match_idx_in   = scan_idx_ff;
            end
            if (!cur_valid && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = scan_idx_ff;
            end
         end
      end else if (dp_cmd.commit) begin
         res_fired_in  = '0;
         res_status_in = STATUS_TICK;
         if (item_cmd_ff == CMD_TICK) begin
            res_fired_in = fired_ff;
         end else if (!event_ok) begin
            res_status_in = STATUS_DROPPED;
         end else if (match_found_ff) begin
            slot_rem_in[match_idx_ff] = item_delay_ff;
            res_status_in             = STATUS_RELOAD;
         end else if (free_found_ff) begin
            slot_valid_in[free_idx_ff] = 1'b1;
            slot_event_in[free_idx_ff] = item_ev_ff;
            slot_rem_in[free_idx_ff]   = item_delay_ff;
            busy_in                    = busy_ff + BUSY_W'(1);
            res_status_in              = STATUS_NEW;
         end else begin
            res_status_in = STATUS_DROPPED;
         end
         res_busy_in = sat_busy(busy_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_valid_ff[i] <= 1'b0;
         end
         busy_ff        <= '0;
         scan_idx_ff    <= '0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
      end else begin
         slot_valid_ff  <= slot_valid_in;
         busy_ff        <= busy_in;
         scan_idx_ff    <= scan_idx_in;
         match_found_ff <= match_found_in;
         free_found_ff  <= free_found_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_event_ff <= slot_event_in;
      slot_rem_ff   <= slot_rem_in;
      fired_ff      <= fired_in;
      match_idx_ff  <= match_idx_in;
      free_idx_ff   <= free_idx_in;
      item_cmd_ff   <= item_cmd_in;
      item_ev_ff    <= item_ev_in;
      item_delay_ff <= item_delay_in;
      res_fired_ff  <= res_fired_in;
      res_status_ff <= res_status_in;
      res_busy_ff   <= res_busy_in;
   end

   assign out_fired_mask = res_fired_ff;
   assign out_set_status = res_status_ff;
   assign out_busy_slots = res_busy_ff;

endmodule

FILE: src/one_shot_timer_table_unit.sv
// Top level of the one-shot event timer table.
`timescale 1ns / 1ps
// Usage:
// The req channel carries one command per transaction. req_tuser selects a timer
// tick (0) or a set of an event timer (1); req_tdata holds the event number and
// the delay in ticks. A set reloads the busy slot that already holds the event,
// else takes the lowest free slot, else is dropped. A tick counts every busy slot
// down and frees the slots that were already at zero, raising their event bits.
// Every command gives exactly one transaction on the rsp channel: the fired mask,
// the set status and the number of busy slots after the command.
// Timing: the slot table is scanned one slot per cycle. After the accepting edge
// come the scan of all NUM_SLOTS slots and the finish state that loads the result
// register, from which the response is shown; a new command is taken only once
// that result is loaded and the controller is back in its idle state.
// The result register frees the input side: the next command is accepted while a
// result still waits. If rsp_tready stays low, the following command finishes
// its scan and then holds until the waiting result is taken.
// Reset (synchronous, active high) frees all slots and empties the result register.
module one_shot_timer_table_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [2:0] event_id, [18:3] delay_ticks, [23:19] zero
   input  logic        req_tuser,   // [0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] fired_mask, [11:8] busy_slots, [15:12] zero
   output logic [1:0]  rsp_tuser    // [1:0] set_status
);
   import ostt_pkg::*;

`include "assert_macros.svh"

   dp_cmd_type            dp_cmd;
   dp_status_type         dp_status;
   logic [MASK_W-1:0]     fired_mask;
   set_status_type        set_status;
   logic [OUT_BUSY_W-1:0] busy_slots;

   ostt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_status  (dp_status),
      .dp_cmd     (dp_cmd)
   );

   ostt_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .dp_cmd         (dp_cmd),
      .dp_status      (dp_status),
      .in_command     (req_tuser),
      .in_event_id    (req_tdata[EVENT_W-1:0]),
      .in_delay_ticks (req_tdata[EVENT_W+DELAY_W-1:EVENT_W]),
      .out_fired_mask (fired_mask),
      .out_set_status (set_status),
      .out_busy_slots (busy_slots)
   );

   assign rsp_tdata = {4'b0000, busy_slots, fired_mask};
   assign rsp_tuser = set_status;

   `ASSERT_ALWAYS(a_cmd_onehot, clock, reset, $onehot0({dp_cmd.start, dp_cmd.step, dp_cmd.commit}))
   `ASSERT_NEXT(a_commit_shows, clock, reset, dp_cmd.commit, rsp_tvalid)
   `ASSERT_NEXT(a_accept_busy, clock, reset, req_tvalid && req_tready, !req_tready)
   `ASSERT_IMPLIES(a_tick_no_status, clock, reset, rsp_tvalid && (rsp_tdata[7:0] != 8'h00), rsp_tuser == STATUS_TICK)
   `ASSERT_IMPLIES(a_busy_bound, clock, reset, rsp_tvalid, rsp_tdata[11:8] <= 4'(NUM_SLOTS > BUSY_MAX ? BUSY_MAX : NUM_SLOTS))

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the one-shot timer table: directed rows, then random commands.
`timescale 1ns / 1ps
module testbench;
   import ostt_pkg::*;

   localparam int NUM_DIRECTED  = 25;
   localparam int NUM_RANDOM    = 1025;
   localparam int QUIET_FROM    = 900;
   localparam int LONG_HOLD_AT  = 400;
   localparam int LONG_HOLD_LEN = 300;
   localparam int DRAIN_AT      = 700;
   localparam int TAIL_CYCLES   = 4 * (NUM_SLOTS + 2);

   typedef struct packed {
      logic [MASK_W-1:0]     mask;
      set_status_type        status;
      logic [OUT_BUSY_W-1:0] busy;
   } timer_result_type;

   typedef struct {
      logic                  command;
      logic [EVENT_W-1:0]    event_id;
      logic [DELAY_W-1:0]    delay;
      bit                    typed;
      logic [MASK_W-1:0]     mask;
      set_status_type        status;
      logic [OUT_BUSY_W-1:0] busy;
   } directed_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // [2:0] event_id, [18:3] delay_ticks, [23:19] zero
   logic        req_tuser;   // [0] command
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [7:0] fired_mask, [11:8] busy_slots, [15:12] zero
   logic [1:0]  rsp_tuser;   // [1:0] set_status

   // Shadow copy of the slot table.
   bit                 slot_busy [NUM_SLOTS];
   logic [EVENT_W-1:0] slot_ev   [NUM_SLOTS];
   logic [DELAY_W-1:0] slot_left [NUM_SLOTS];

   timer_result_type awaited_timer_results[$];
   directed_row_type directed_rows[NUM_DIRECTED];

   int errors     = 0;
   int n_ticks    = 0;
   int n_sets     = 0;
   int n_reloads  = 0;
   int n_new      = 0;
   int n_dropped  = 0;
   int n_expired  = 0;
   int n_checked  = 0;

   bit sender_gaps    = 1'b0;
   bit receiver_gaps  = 1'b0;
   bit long_hold_req  = 1'b0;

   one_shot_timer_table_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("testbench: FAIL");
      $finish;
   end

   // Applies one command to the shadow table and returns the response it must produce.
   function automatic timer_result_type step_timer_table(input logic command,
                                                        input logic [EVENT_W-1:0] ev,
                                                        input logic [DELAY_W-1:0] delay);
      timer_result_type r;
      int               busy;
      bit               done;
      r.mask   = '0;
      r.status = STATUS_TICK;
      done     = 1'b0;
      busy     = 0;
      if (command == CMD_TICK) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_busy[i]) begin
               if (slot_left[i] != 0) begin
                  slot_left[i] = slot_left[i] - 1'b1;
               end else begin
                  if (int'(slot_ev[i]) < MASK_W) begin
                     r.mask[slot_ev[i]] = 1'b1;
                  end
                  slot_busy[i] = 1'b0;
               end
            end
         end
      end else begin
         r.status = STATUS_DROPPED;
         if (int'(ev) >= NUM_EVENTS) begin
            done = 1'b1;
         end
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!done && slot_busy[i] && slot_ev[i] == ev) begin
               slot_left[i] = delay;
               r.status     = STATUS_RELOAD;
               done         = 1'b1;
            end
         end
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!done && !slot_busy[i]) begin
               slot_busy[i] = 1'b1;
               slot_ev[i]   = ev;
               slot_left[i] = delay;
               r.status     = STATUS_NEW;
               done         = 1'b1;
            end
         end
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (slot_busy[i]) begin
            busy++;
         end
      end
      r.busy = (busy > BUSY_MAX) ? OUT_BUSY_W'(BUSY_MAX) : OUT_BUSY_W'(busy);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      errors++;
      $display("%0t: response %0d: %s is %0h, should be %0h", $realtime, n_checked, what,
               got, want);
   endtask

   // Offers one command, waits for the transaction and returns the predicted response.
   task automatic offer_command(input logic command, input logic [EVENT_W-1:0] ev,
                                input logic [DELAY_W-1:0] delay,
                                output timer_result_type predicted);
      req_tvalid <= 1'b1;
      req_tuser  <= command;
      req_tdata  <= {5'd0, delay, ev};
      do @(posedge clock); while (!req_tready);
      predicted = step_timer_table(command, ev, delay);
      if (command == CMD_TICK) begin
         n_ticks++;
         n_expired += $countones(predicted.mask);
      end else begin
         n_sets++;
         case (predicted.status)
            STATUS_RELOAD: n_reloads++;
            STATUS_NEW:    n_new++;
            default:       n_dropped++;
         endcase
      end
   endtask

   task automatic sender_gap();
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   initial begin
      reset <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   // Response side: random stalls, one long hold on request, no stalls when switched off.
   initial begin
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_LEN) @(posedge clock);
         end else if (receiver_gaps && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      timer_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_checked++;
         if (awaited_timer_results.size() == 0) begin
            errors++;
            $display("%0t: response with no command outstanding", $realtime);
         end else begin
            want = awaited_timer_results.pop_front();
            if (rsp_tdata[7:0] !== want.mask) begin
               report_mismatch("fired_mask", rsp_tdata[7:0], want.mask);
            end
            if (rsp_tuser !== want.status) begin
               report_mismatch("set_status", rsp_tuser, want.status);
            end
            if (rsp_tdata[11:8] !== want.busy) begin
               report_mismatch("busy_slots", rsp_tdata[11:8], want.busy);
            end
         end
      end
   end

   initial begin
      timer_result_type   predicted;
      timer_result_type   typed_result;
      logic               command;
      logic [EVENT_W-1:0] ev;
      logic [DELAY_W-1:0] delay;
      int                 sel;

      // Directed rows; typed responses only where they are plain to see.
      directed_rows[0]  = '{CMD_TICK, 3'd0, 16'd0,     1'b1, 8'h00, STATUS_TICK,   4'd0};
      directed_rows[1]  = '{CMD_SET,  3'd0, 16'd0,     1'b1, 8'h00, STATUS_NEW,    4'd1};
      directed_rows[2]  = '{CMD_TICK, 3'd0, 16'd0,     1'b1, 8'h01, STATUS_TICK,   4'd0};
      directed_rows[3]  = '{CMD_SET,  3'd7, 16'hFFFF,  1'b1, 8'h00, STATUS_NEW,    4'd1};
      directed_rows[4]  = '{CMD_SET,  3'd7, 16'd1,     1'b1, 8'h00, STATUS_RELOAD, 4'd1};
      directed_rows[5]  = '{CMD_TICK, 3'd0, 16'd0,     1'b1, 8'h00, STATUS_TICK,   4'd1};
      directed_rows[6]  = '{CMD_TICK, 3'd0, 16'd0,     1'b1, 8'h80, STATUS_TICK,   4'd0};
      for (int k = 0; k < NUM_SLOTS; k++) begin
         directed_rows[7 + k] = '{CMD_SET, EVENT_W'(k), 16'd0, 1'b1, 8'h00, STATUS_NEW,
                                  OUT_BUSY_W'(k + 1)};
      end
      // A full table still reloads the slot that holds the same event.
      directed_rows[15] = '{CMD_SET,  3'd3, 16'hAAAA,  1'b1, 8'h00, STATUS_RELOAD, 4'd8};
      directed_rows[16] = '{CMD_SET,  3'd5, 16'h5555,  1'b1, 8'h00, STATUS_RELOAD, 4'd8};
      directed_rows[17] = '{CMD_TICK, 3'd0, 16'd0,     1'b1, 8'hD7, STATUS_TICK,   4'd2};
      directed_rows[18] = '{CMD_SET,  3'd1, 16'd3,     1'b1, 8'h00, STATUS_NEW,    4'd3};
      directed_rows[19] = '{CMD_SET,  3'd1, 16'd2,     1'b1, 8'h00, STATUS_RELOAD, 4'd3};
      directed_rows[20] = '{CMD_TICK, 3'd6, 16'h1234,  1'b0, 8'h00, STATUS_TICK,   4'd0};
      directed_rows[21] = '{CMD_TICK, 3'd2, 16'd0,     1'b0, 8'h00, STATUS_TICK,   4'd0};
      directed_rows[22] = '{CMD_TICK, 3'd4, 16'd9,     1'b0, 8'h00, STATUS_TICK,   4'd0};
      directed_rows[23] = '{CMD_SET,  3'd5, 16'd0,     1'b0, 8'h00, STATUS_TICK,   4'd0};
      directed_rows[24] = '{CMD_TICK, 3'd0, 16'd0,     1'b0, 8'h00, STATUS_TICK,   4'd0};

      req_tvalid <= 1'b0;
      req_tuser  <= CMD_TICK;
      req_tdata  <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         slot_busy[i] = 1'b0;
         slot_ev[i]   = '0;
         slot_left[i] = '0;
      end
      do @(posedge clock); while (reset);

      sender_gaps   = 1'b1;
      receiver_gaps = 1'b1;
      foreach (directed_rows[i]) begin
         offer_command(directed_rows[i].command, directed_rows[i].event_id,
                       directed_rows[i].delay, predicted);
         if (directed_rows[i].typed) begin
            typed_result.mask   = directed_rows[i].mask;
            typed_result.status = directed_rows[i].status;
            typed_result.busy   = directed_rows[i].busy;
            awaited_timer_results.push_back(typed_result);
         end else begin
            awaited_timer_results.push_back(predicted);
         end
         sender_gap();
      end

      // Random commands: small delays dominate so that timers keep expiring and slots turn over.
      for (int r = 0; r < NUM_RANDOM; r++) begin
         if (r == LONG_HOLD_AT) begin
            long_hold_req = 1'b1;
         end
         if (r == DRAIN_AT) begin
            // Withdraw the last transaction so that it is not taken again while draining.
            req_tvalid <= 1'b0;
            while (awaited_timer_results.size() != 0) @(posedge clock);
         end
         sender_gaps   = (r < QUIET_FROM) && !(r >= 200 && r < 300) &&
                         !(r >= LONG_HOLD_AT && r < LONG_HOLD_AT + 60);
         receiver_gaps = (r < QUIET_FROM) && !(r >= 500 && r < 600);
         command = ($urandom_range(0, 99) < 55) ? CMD_TICK : CMD_SET;
         ev      = EVENT_W'($urandom_range(0, NUM_EVENTS - 1));
         sel     = $urandom_range(0, 99);
         if (sel < 70) begin
            delay = DELAY_W'($urandom_range(0, 12));
         end else if (sel < 90) begin
            delay = DELAY_W'($urandom_range(13, 300));
         end else begin
            delay = DELAY_W'($urandom_range(0, 65535));
         end
         offer_command(command, ev, delay, predicted);
         awaited_timer_results.push_back(predicted);
         sender_gap();
      end
      req_tvalid <= 1'b0;

      while (awaited_timer_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d commands: %0d ticks, %0d sets (%0d reloads, %0d new, %0d dropped).",
               n_ticks + n_sets, n_ticks, n_sets, n_reloads, n_new, n_dropped);
      $display("%0d timers expired; %0d responses compared, %0d mismatches.",
               n_expired, n_checked, errors);
      if (errors == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

FILE: one_shot_timer_table_unit.f
+incdir+src
src/ostt_pkg.sv
src/ostt_ctrl.sv
src/ostt_dp.sv
src/one_shot_timer_table_unit.sv
tb/testbench.sv
